/* sv/ssched_pkg.sv */
// ssched_pkg: types and constants shared by the step scheduler modules
// no dependencies; imported by ssched_div, ssched_dp, ssched_ctrl and the top level
package ssched_pkg;

	localparam int TIME_W  = 32;
	localparam int DELTA_W = 16;
	localparam int FLASH_W = 16;
	localparam int BYTE_W  = 8;
	localparam int ARGS_W  = 3;
	localparam int DIV_CNT_W = $clog2(TIME_W);

	localparam logic [TIME_W-1:0]  TIME_NONE     = '1;
	localparam logic [TIME_W-1:0]  RESET_PERIOD  = TIME_W'(7812);
	localparam logic [FLASH_W-1:0] RESET_FLASH   = FLASH_W'(4000);
	localparam logic [ARGS_W-1:0]  PERIOD_ARGS   = ARGS_W'(4);

	localparam logic [BYTE_W-1:0] CMD_LED_OFF = 8'hf0;
	localparam logic [BYTE_W-1:0] CMD_LED_ON  = 8'hf1;
	localparam logic [BYTE_W-1:0] CMD_PERIOD  = 8'h10;

	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	typedef struct packed {
		logic               operation;
		logic [BYTE_W-1:0]  cmd_byte;
		logic [DELTA_W-1:0] tick_delta;
	} item_t;

	typedef struct packed {
		logic step_pulse;
		logic led_lit;
		logic motor_running;
	} result_t;

	// controller to datapath strobes, at most one of them per cycle
	typedef struct packed {
		logic latch_in;
		logic do_cmd;
		logic tick_add;
		logic tick_step;
		logic tick_led;
		logic ap_set;
		logic ap_cmp;
		logic ap_rem;
		logic ap_sum;
		logic ap_final;
		logic load_out;
	} ssched_cmd_t;

	typedef struct packed {
		logic delta_zero;
		logic arg_last;
		logic period_zero;
		logic next_idle;
		logic next_gt_limit;
		logic div_done;
	} ssched_sts_t;

endpackage

/* sv/ssched_div.sv */
// ssched_div: iterative unsigned remainder unit, one quotient bit per cycle
// depends on ssched_pkg
module ssched_div
	import ssched_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [TIME_W-1:0] dividend,
	input  logic [TIME_W-1:0] divisor,
	output logic              done,
	output logic [TIME_W-1:0] remainder
);

	localparam logic [DIV_CNT_W-1:0] LAST_STEP = DIV_CNT_W'(TIME_W - 1);

	logic                 busy_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [TIME_W-1:0]    rem_q;
	logic [TIME_W-1:0]    dvd_q;
	logic [TIME_W:0]      rem_sh;
	logic [TIME_W:0]      rem_sub;
	logic                 fits;

	assign rem_sh  = {rem_q, dvd_q[TIME_W-1]};
	assign rem_sub = rem_sh - {1'b0, divisor};
	assign fits    = rem_sh >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == LAST_STEP) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? rem_sub[TIME_W-1:0] : rem_sh[TIME_W-1:0];
			dvd_q <= {dvd_q[TIME_W-2:0], 1'b0};
		end
	end

	// the last step lands on the same edge the controller moves on
	assign done      = busy_q && (cnt_q == LAST_STEP);
	assign remainder = rem_q;

endmodule

/* sv/ssched_dp.sv */
// ssched_dp: scheduler state, time arithmetic, command parsing and result register
// depends on ssched_pkg and ssched_div
module ssched_dp
	import ssched_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  ssched_cmd_t        cmd,
	output ssched_sts_t        sts,
	input  item_t              item,
	input  logic               cfg_we,
	input  logic [FLASH_W-1:0] cfg_data,
	output result_t            result
);

	// architectural state
	logic [TIME_W-1:0]  elapsed_q;
	logic [TIME_W-1:0]  period_q;
	logic [TIME_W-1:0]  next_q;
	logic [TIME_W-1:0]  led_off_q;
	logic               led_q;
	logic [ARGS_W-1:0]  args_left_q;
	logic [TIME_W-1:0]  shift_q;
	logic [FLASH_W-1:0] flash_q;

	// working registers
	item_t              item_q;
	logic               flash_hit_q;
	logic               pulse_q;
	logic [TIME_W-1:0]  limit_q;
	logic [TIME_W-1:0]  dividend_q;
	logic [TIME_W-1:0]  part_q;
	logic [TIME_W:0]    sub_q;
	result_t            result_q;

	logic [TIME_W-1:0]  dividend;
	logic [TIME_W-1:0]  rem;
	logic               div_done;
	logic               step_due;

	// next - limit - 1, the distance less one
	assign dividend = next_q + ~limit_q;
	assign step_due = (next_q != TIME_NONE) && (elapsed_q >= next_q);

	ssched_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.ap_cmp && (next_q > limit_q)),
		.dividend  (dividend),
		.divisor   (period_q),
		.done      (div_done),
		.remainder (rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elapsed_q   <= '0;
			period_q    <= RESET_PERIOD;
			next_q      <= TIME_NONE;
			led_off_q   <= TIME_NONE;
			led_q       <= 1'b0;
			args_left_q <= '0;
			shift_q     <= '0;
			flash_q     <= RESET_FLASH;
		end else begin
			if (cfg_we) begin
				flash_q <= cfg_data;
			end
			if (cmd.do_cmd) begin
				if (args_left_q != '0) begin
					shift_q     <= {shift_q[TIME_W-BYTE_W-1:0], item_q.cmd_byte};
					args_left_q <= args_left_q - 1'b1;
				end else begin
					case (item_q.cmd_byte)
						CMD_LED_OFF: led_q <= 1'b0;
						CMD_LED_ON:  led_q <= 1'b1;
						CMD_PERIOD: begin
							args_left_q <= PERIOD_ARGS;
							shift_q     <= '0;
						end
						default: ;
					endcase
				end
			end else if (cmd.tick_add) begin
				if (item_q.tick_delta != '0) begin
					elapsed_q <= elapsed_q + {{(TIME_W-DELTA_W){1'b0}}, item_q.tick_delta};
				end
			end else if (cmd.tick_step) begin
				if (flash_hit_q) begin
					led_q     <= 1'b1;
					led_off_q <= elapsed_q + {{(TIME_W-FLASH_W){1'b0}}, flash_q};
				end
				if (step_due) begin
					next_q <= next_q + period_q;
				end
			end else if (cmd.tick_led) begin
				if ((led_off_q != TIME_NONE) && (elapsed_q >= led_off_q)) begin
					led_q     <= 1'b0;
					led_off_q <= TIME_NONE;
				end
			end else if (cmd.ap_set) begin
				period_q <= shift_q;
				if (shift_q == '0) begin
					next_q <= TIME_NONE;
				end else if (next_q == TIME_NONE) begin
					next_q <= elapsed_q;
				end
			end else if (cmd.ap_final) begin
				// pulled back past zero: restart from now
				if (sub_q > {1'b0, next_q}) begin
					next_q <= elapsed_q;
				end else begin
					next_q <= next_q - sub_q[TIME_W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			item_q  <= item;
			pulse_q <= 1'b0;
		end
		if (cmd.tick_add) begin
			flash_hit_q <= item_q.tick_delta > DELTA_W'(1);
		end
		if (cmd.tick_step) begin
			pulse_q <= step_due;
		end
		if (cmd.ap_set) begin
			limit_q <= elapsed_q + shift_q;
		end
		if (cmd.ap_cmp) begin
			dividend_q <= dividend;
		end
		// k * period = (diff - 1) - rem + period
		if (cmd.ap_rem) begin
			part_q <= dividend_q - rem;
		end
		if (cmd.ap_sum) begin
			sub_q <= {1'b0, part_q} + {1'b0, period_q};
		end
		if (cmd.load_out) begin
			result_q.step_pulse    <= pulse_q;
			result_q.led_lit       <= led_q;
			result_q.motor_running <= next_q != TIME_NONE;
		end
	end

	assign sts.delta_zero    = item_q.tick_delta == '0;
	assign sts.arg_last      = args_left_q == ARGS_W'(1);
	assign sts.period_zero   = shift_q == '0;
	assign sts.next_idle     = next_q == TIME_NONE;
	assign sts.next_gt_limit = next_q > limit_q;
	assign sts.div_done      = div_done;

	assign result = result_q;

endmodule

/* sv/ssched_ctrl.sv */
// ssched_ctrl: sequencing state machine and handshakes for the step scheduler
// depends on ssched_pkg
module ssched_ctrl
	import ssched_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	input  logic        item_op,
	output logic        item_stall,
	output logic        result_valid,
	input  logic        result_stall,
	input  ssched_sts_t sts,
	output ssched_cmd_t cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_CMD,
		S_TICK1,
		S_TICK2,
		S_TICK3,
		S_AP0,
		S_AP1,
		S_DIV,
		S_AP2,
		S_AP3,
		S_AP4,
		S_DONE
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   accept;
	logic   out_free;

	assign accept   = (state_q == S_IDLE) && item_valid;
	assign out_free = !out_valid_q || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !result_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (item_valid) begin
						state_q <= (item_op == OP_TICK) ? S_TICK1 : S_CMD;
					end
				end
				S_CMD:   state_q <= sts.arg_last ? S_AP0 : S_DONE;
				S_TICK1: state_q <= sts.delta_zero ? S_DONE : S_TICK2;
				S_TICK2: state_q <= S_TICK3;
				S_TICK3: state_q <= S_DONE;
				S_AP0:   state_q <= (sts.period_zero || sts.next_idle) ? S_DONE : S_AP1;
				S_AP1:   state_q <= sts.next_gt_limit ? S_DIV : S_DONE;
				S_DIV: begin
					if (sts.div_done) begin
						state_q <= S_AP2;
					end
				end
				S_AP2:   state_q <= S_AP3;
				S_AP3:   state_q <= S_AP4;
				S_AP4:   state_q <= S_DONE;
				S_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd           = '0;
		cmd.latch_in  = accept;
		cmd.do_cmd    = state_q == S_CMD;
		cmd.tick_add  = state_q == S_TICK1;
		cmd.tick_step = state_q == S_TICK2;
		cmd.tick_led  = state_q == S_TICK3;
		cmd.ap_set    = state_q == S_AP0;
		cmd.ap_cmp    = state_q == S_AP1;
		cmd.ap_rem    = state_q == S_AP2;
		cmd.ap_sum    = state_q == S_AP3;
		cmd.ap_final  = state_q == S_AP4;
		cmd.load_out  = (state_q == S_DONE) && out_free;
	end

	assign item_stall   = state_q != S_IDLE;
	assign result_valid = out_valid_q;

endmodule

/* sv/stepper_step_scheduler_unit.sv */
// stepper_step_scheduler_unit: one item at a time, one result per item
// per item: a command byte runs S_CMD, a tick S_TICK1 to S_TICK3 (zero delta: S_TICK1),
// a period command's last byte S_CMD, up to S_AP0, S_AP1, S_DIV (pullback remainder unit),
// S_AP2 to S_AP4, then S_DONE; the next item is taken the cycle after the result is loaded
// arst_n resets the scheduler to time 0, period 7812, motor idle, led dark, flash time 4000
// depends on ssched_pkg, ssched_ctrl, ssched_dp
module stepper_step_scheduler_unit
	import ssched_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  item_t              item,
	output logic               result_valid,
	input  logic               result_stall,
	output result_t            result,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [FLASH_W-1:0] cfg_data
);

	ssched_cmd_t cmd;
	ssched_sts_t sts;

	assign cfg_ready = 1'b1;

	ssched_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_op      (item.operation),
		.item_stall   (item_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.sts          (sts),
		.cmd          (cmd)
	);

	ssched_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.item     (item),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.result   (result)
	);

endmodule

/* dv/tb_stepper_step_scheduler_unit.sv */
// tb_stepper_step_scheduler_unit: self-checking bench for the stepper step scheduler
// a queue-fed driver, a result monitor with an in-bench schedule predictor, and a watchdog
// depends on ssched_pkg and stepper_step_scheduler_unit
module tb_stepper_step_scheduler_unit;
	import ssched_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_LIMIT = 2000;
	localparam int LONG_HOLD  = 80;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               item_valid = 1'b0;
	logic               item_stall;
	item_t              item = '0;
	logic               result_valid;
	logic               result_stall = 1'b0;
	result_t            result;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [FLASH_W-1:0] cfg_data = '0;

	stepper_step_scheduler_unit u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// predicted scheduler state
	logic [TIME_W-1:0]  sch_elapsed  = '0;
	logic [TIME_W-1:0]  sch_period   = RESET_PERIOD;
	logic [TIME_W-1:0]  sch_next     = TIME_NONE;
	logic [TIME_W-1:0]  sch_led_off  = TIME_NONE;
	logic               sch_led      = 1'b0;
	logic [ARGS_W-1:0]  sch_args     = '0;
	logic [TIME_W-1:0]  sch_shift    = '0;
	logic [FLASH_W-1:0] sch_flash    = RESET_FLASH;

	item_t   item_q[$];
	result_t status_q[$];

	int  n_queued, n_results, n_errors, n_pulses, n_pullbacks, n_floored, n_holds;
	int  idle_cycles;
	bit  quiet;
	logic in_acc = 1'b0;

	function automatic void retime_period();
		logic [TIME_W-1:0] lim;
		logic [TIME_W-1:0] gap;
		logic [63:0]       k;
		logic [63:0]       sub;
		sch_period = sch_shift;
		if (sch_period == '0) begin
			sch_next = TIME_NONE;
		end else if (sch_next == TIME_NONE) begin
			sch_next = sch_elapsed;
		end else begin
			lim = sch_elapsed + sch_period;
			if (sch_next > lim) begin
				n_pullbacks++;
				gap = sch_next - lim;
				k = ({32'b0, gap} - 64'd1) / {32'b0, sch_period} + 64'd1;
				sub = k * {32'b0, sch_period};
				if (sub > {32'b0, sch_next}) begin
					// pulling back would go below zero
					sch_next = sch_elapsed;
					n_floored++;
				end else begin
					sch_next = sch_next - sub[TIME_W-1:0];
				end
			end
		end
	endfunction

	function automatic result_t advance_scheduler(input item_t it);
		result_t r;
		r = '0;
		if (it.operation == OP_BYTE) begin
			if (sch_args != '0) begin
				sch_shift = {sch_shift[TIME_W-BYTE_W-1:0], it.cmd_byte};
				sch_args = sch_args - 1'b1;
				if (sch_args == '0)
					retime_period();
			end else begin
				case (it.cmd_byte)
					CMD_LED_OFF: sch_led = 1'b0;
					CMD_LED_ON:  sch_led = 1'b1;
					CMD_PERIOD: begin
						sch_args = PERIOD_ARGS;
						sch_shift = '0;
					end
					default: ;
				endcase
			end
		end else if (it.tick_delta != '0) begin
			sch_elapsed = sch_elapsed + {16'b0, it.tick_delta};
			if (it.tick_delta > 16'd1) begin
				sch_led = 1'b1;
				sch_led_off = sch_elapsed + {16'b0, sch_flash};
			end
			if (sch_next != TIME_NONE && sch_elapsed >= sch_next) begin
				r.step_pulse = 1'b1;
				sch_next = sch_next + sch_period;
				n_pulses++;
			end
			if (sch_led_off != TIME_NONE && sch_elapsed >= sch_led_off) begin
				sch_led = 1'b0;
				sch_led_off = TIME_NONE;
			end
		end
		r.led_lit = sch_led;
		r.motor_running = (sch_next != TIME_NONE);
		return r;
	endfunction

	function automatic void push_byte(input logic [BYTE_W-1:0] b);
		item_t it;
		it.operation = OP_BYTE;
		it.cmd_byte = b;
		it.tick_delta = DELTA_W'($urandom());
		item_q.push_back(it);
		n_queued++;
	endfunction

	function automatic void push_tick(input logic [DELTA_W-1:0] d);
		item_t it;
		it.operation = OP_TICK;
		it.cmd_byte = BYTE_W'($urandom());
		it.tick_delta = d;
		item_q.push_back(it);
		n_queued++;
	endfunction

	function automatic void push_period(input logic [TIME_W-1:0] v);
		push_byte(CMD_PERIOD);
		push_byte(v[31:24]);
		push_byte(v[23:16]);
		push_byte(v[15:8]);
		push_byte(v[7:0]);
	endfunction

	// well-formed command and tick runs, with some noise and cut-off commands
	function automatic void mixed_traffic(input int n_items);
		int first;
		int runs;
		int r;
		logic [TIME_W-1:0] v;
		first = n_queued;
		while (n_queued - first < n_items) begin
			r = $urandom_range(0, 19);
			if (r < 6) begin
				case ($urandom_range(0, 5))
					0: v = $urandom_range(1, 8);
					1: v = $urandom_range(1, 400);
					2: v = $urandom_range(1, 200000);
					3: v = $urandom();
					4: v = '0;
					default: v = TIME_NONE - $urandom_range(0, 1000);
				endcase
				push_period(v);
			end else if (r < 14) begin
				runs = $urandom_range(1, 16);
				repeat (runs) begin
					case ($urandom_range(0, 19))
						0: push_tick('0);
						1: push_tick('1);
						2, 3, 4: push_tick(DELTA_W'($urandom_range(2, 65535)));
						5, 6: push_tick(DELTA_W'($urandom_range(2, 40)));
						default: push_tick(16'd1);
					endcase
				end
			end else if (r < 17) begin
				push_byte($urandom_range(0, 1) ? CMD_LED_ON : CMD_LED_OFF);
			end else if (r < 18) begin
				// period command cut short, later items become its arguments
				push_byte(CMD_PERIOD);
				repeat ($urandom_range(0, 3))
					push_byte(BYTE_W'($urandom_range(0, 255)));
			end else begin
				push_byte(BYTE_W'($urandom_range(0, 255)));
			end
		end
	endfunction

	task automatic drain();
		do @(posedge clk);
		while (item_q.size() != 0 || item_valid || status_q.size() != 0);
	endtask

	task automatic write_flash(input logic [FLASH_W-1:0] v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk);
		while (!cfg_ready);
		sch_flash = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// item driver
	int gap_in, calm_in;
	always @(negedge clk) begin
		if (arst_n && !(item_valid && !in_acc)) begin
			if (item_valid && in_acc) begin
				if (!quiet && calm_in == 0 && $urandom_range(0, 3) == 0)
					gap_in = $urandom_range(1, 7);
				if (calm_in > 0)
					calm_in--;
				else if ($urandom_range(0, 15) == 0)
					calm_in = $urandom_range(10, 40);
			end
			if (gap_in > 0) begin
				gap_in--;
				item_valid <= 1'b0;
			end else if (item_q.size() != 0) begin
				item_valid <= 1'b1;
				item <= item_q.pop_front();
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// result stall: short random bursts, calm stretches and a few long holds
	int stall_left, calm_out, hold_idx;
	int hold_marks[2] = '{300, 650};
	always @(negedge clk) begin
		logic s;
		s = 1'b0;
		if (hold_idx < 2 && n_results >= hold_marks[hold_idx]) begin
			hold_idx++;
			n_holds++;
			stall_left = LONG_HOLD;
		end
		if (calm_out > 0)
			calm_out--;
		else if ($urandom_range(0, 63) == 0)
			calm_out = $urandom_range(30, 120);
		if (stall_left > 0) begin
			stall_left--;
			s = 1'b1;
		end else if (arst_n && !quiet && calm_out == 0 && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(1, 7) - 1;
			s = 1'b1;
		end
		result_stall <= s;
	end

	// monitor and predictor
	always @(posedge clk) begin
		result_t want;
		if (!arst_n) begin
			in_acc <= 1'b0;
		end else begin
			in_acc <= item_valid && !item_stall;
			if (item_valid && !item_stall)
				status_q.push_back(advance_scheduler(item));
			if (result_valid && !result_stall) begin
				n_results++;
				if (status_q.size() == 0) begin
					$display("%0t ns: result %b with no item pending", $time, result);
					n_errors++;
				end else begin
					want = status_q.pop_front();
					if (result.step_pulse !== want.step_pulse || result.led_lit !== want.led_lit
						|| result.motor_running !== want.motor_running) begin
						$display("%0t ns: mismatch pulse/led/run expected %b%b%b actual %b%b%b",
							$time, want.step_pulse, want.led_lit, want.motor_running,
							result.step_pulse, result.led_lit, result.motor_running);
						n_errors++;
					end
				end
			end
		end
	end

	// watchdog on cycles with no handshake anywhere
	always @(posedge clk) begin
		if (!arst_n || (item_valid && !item_stall) || (result_valid && !result_stall)
			|| (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t ns: no progress for %0d cycles, %0d items outstanding", $time,
				IDLE_LIMIT, status_q.size());
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: zero delta, led commands, unknown byte, period retiming corners
		push_tick('0);
		push_byte(CMD_LED_ON);
		push_byte(CMD_LED_OFF);
		push_byte(8'h55);
		push_period(32'd3);
		push_tick(16'd1);
		push_tick('1);
		push_period(32'h8000_0000);
		push_tick(16'd1);
		// regular pullback, then one with a wrapped limit whose pullback would go below zero
		push_period(32'd1000);
		push_period(32'hffff_fff0);
		drain();

		write_flash('0);
		mixed_traffic(250);
		drain();

		write_flash('1);
		mixed_traffic(250);
		drain();

		// next step time lands exactly on the idle marker
		write_flash(FLASH_W'($urandom_range(2, 65534)));
		repeat (sch_args)
			push_byte(8'h00);
		push_period('0);
		push_period(~sch_elapsed);
		push_tick(16'd1);
		mixed_traffic(250);
		drain();

		write_flash(16'd1);
		mixed_traffic(120);
		drain();
		quiet = 1'b1;
		mixed_traffic(150);
		drain();
		repeat (60) @(posedge clk);

		$display("run covered %0d items and %0d results: %0d step pulses, %0d long holds",
			n_queued, n_results, n_pulses, n_holds);
		$display("period retimes: %0d pulled back, %0d of them clamped to current time",
			n_pullbacks, n_floored);
		if (n_errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

/* filelist.f */
sv/ssched_pkg.sv
sv/ssched_div.sv
sv/ssched_dp.sv
sv/ssched_ctrl.sv
sv/stepper_step_scheduler_unit.sv
dv/tb_stepper_step_scheduler_unit.sv
